@@ design/rmss_pkg.sv @@
// shared types and codes for the running median sorted store
package rmss_pkg;

  // width of one stored amount
  localparam int unsigned VALUE_W = 32;
  // width of the stored count field on the result channel
  localparam int unsigned COUNT_W = 11;

  // input command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what every cell of a chain does when the chain is updated
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,   // keep own value
    OP_INSERT = 2'd1,   // sorted insert of the broadcast value
    OP_PUSH   = 2'd2,   // shift away from the head, head takes the front value
    OP_POPINS = 2'd3    // drop the head and sorted insert of the broadcast value
  } cell_op_t;

  // control broadcast along a chain
  typedef struct packed {
    cell_op_t             op;
    logic [VALUE_W-1:0]   value;
  } cell_ctl_t;

endpackage

@@ design/rmss_cell.sv @@
// one cell of a sorted chain: holds one value and trades it with its neighbors
module rmss_cell #(
  parameter bit FIRST   = 1'b0,
  parameter bit DESCEND = 1'b0
) (
  input  logic                          clk,
  input  rmss_pkg::cell_ctl_t           ctl_i,
  input  logic [rmss_pkg::VALUE_W-1:0]  left_i,
  input  logic                          left_le_i,
  input  logic [rmss_pkg::VALUE_W-1:0]  right_i,
  input  logic                          right_le_i,
  input  logic                          occ_i,
  input  logic                          right_occ_i,
  output logic [rmss_pkg::VALUE_W-1:0]  val_o,
  output logic                          le_o
);

  logic [rmss_pkg::VALUE_W-1:0] val_r;
  logic [rmss_pkg::VALUE_W-1:0] val_nxt;

  // own value sits before the broadcast value in chain order
  assign le_o  = DESCEND ? (val_r >= ctl_i.value) : (val_r <= ctl_i.value);
  assign val_o = val_r;

  // next value from own, neighbors or the broadcast value
  always_comb begin
    unique case (ctl_i.op)
      rmss_pkg::OP_HOLD:   val_nxt = val_r;
      rmss_pkg::OP_INSERT: begin
        if (occ_i && le_o) val_nxt = val_r;
        else if (FIRST || left_le_i) val_nxt = ctl_i.value;
        else val_nxt = left_i;
      end
      rmss_pkg::OP_PUSH:   val_nxt = left_i;
      rmss_pkg::OP_POPINS: begin
        if (right_occ_i && right_le_i) val_nxt = right_i;
        else if (le_o) val_nxt = ctl_i.value;
        else val_nxt = val_r;
      end
      default:             val_nxt = val_r;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ design/rmss_chain.sv @@
// row of sorted cells, head at cell zero, occupancy from the fill size
module rmss_chain #(
  parameter int unsigned DEPTH   = 512,
  parameter int unsigned SW      = 11,
  parameter bit          DESCEND = 1'b0
) (
  input  logic                          clk,
  input  rmss_pkg::cell_ctl_t           ctl_i,
  input  logic [rmss_pkg::VALUE_W-1:0]  front_i,
  input  logic [SW-1:0]                 size_i,
  output logic [rmss_pkg::VALUE_W-1:0]  head_o,
  output logic                          head_le_o
);

  logic [rmss_pkg::VALUE_W-1:0] val [DEPTH];
  logic [DEPTH-1:0]             le;
  logic [DEPTH-1:0]             occ;

  assign head_o    = val[0];
  assign head_le_o = le[0];

  // cells and their neighbor wiring
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [rmss_pkg::VALUE_W-1:0] left_v;
    logic                         left_le;
    logic [rmss_pkg::VALUE_W-1:0] right_v;
    logic                         right_le;
    logic                         right_occ;

    assign occ[j] = (size_i > SW'(j));

    if (j == 0) begin : g_head
      assign left_v  = front_i;
      assign left_le = 1'b0;
    end else begin : g_mid
      assign left_v  = val[j-1];
      assign left_le = le[j-1];
    end

    if (j == DEPTH - 1) begin : g_tail
      assign right_v   = '0;
      assign right_le  = 1'b0;
      assign right_occ = 1'b0;
    end else begin : g_inner
      assign right_v   = val[j+1];
      assign right_le  = le[j+1];
      assign right_occ = (size_i > SW'(j + 1));
    end

    rmss_cell #(
      .FIRST   (j == 0),
      .DESCEND (DESCEND)
    ) u_cell (
      .clk         (clk),
      .ctl_i       (ctl_i),
      .left_i      (left_v),
      .left_le_i   (left_le),
      .right_i     (right_v),
      .right_le_i  (right_le),
      .occ_i       (occ[j]),
      .right_occ_i (right_occ),
      .val_o       (val[j]),
      .le_o        (le[j])
    );
  end

endmodule

@@ design/running_median_sorted_store_top.sv @@
// running upper median: two sorted cell chains split at the median
//
//  channel | ports                                   | dir | meaning
//  in      | in_valid in_ready in_command in_value     | in  | insert or query beat
//  out     | out_valid out_ready out_median            | out | one result beat per item
//          | out_stored_count out_status             |     |
//
// one item a cycle while in_ready is high; its result is captured in the output register on acceptance
// the upper chain keeps the median in its head cell, so a query reads one register
// an insert below capacity updates one or both chains and the count in that same cycle
// reset clears the count and the output valid only; cell contents need no clear
// in_ready falls only while a result waits and out_ready is low
module running_median_sorted_store_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [rmss_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rmss_pkg::VALUE_W-1:0]  out_median,
  output logic [rmss_pkg::COUNT_W-1:0]  out_stored_count,
  output logic [1:0]                    out_status
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NU = (CAPACITY + 1) / 2;
  localparam int unsigned NL = CAPACITY / 2;

  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic                          out_valid_r;
  logic [rmss_pkg::VALUE_W-1:0]  median_r;
  logic [rmss_pkg::VALUE_W-1:0]  median_nxt;
  logic [rmss_pkg::COUNT_W-1:0]  scount_r;
  logic [rmss_pkg::COUNT_W-1:0]  scount_nxt;
  rmss_pkg::status_t             status_r;
  rmss_pkg::status_t             status_nxt;

  logic                          accept;
  logic                          is_insert;
  logic                          full;
  logic                          empty;
  logic                          do_insert;
  logic [CW:0]                   u_size_w;
  logic [CW-1:0]                 u_size;
  logic [CW-1:0]                 l_size;
  logic [CW+rmss_pkg::COUNT_W-1:0] count_ext;
  rmss_pkg::cell_ctl_t           u_ctl;
  rmss_pkg::cell_ctl_t           l_ctl;
  logic [rmss_pkg::VALUE_W-1:0]  u_head;
  logic                          u_head_le;
  logic [rmss_pkg::VALUE_W-1:0]  l_head;
  logic                          l_head_le;
  logic [rmss_pkg::VALUE_W-1:0]  l_front;
  logic [rmss_pkg::VALUE_W-1:0]  u_front;

  // handshake through the output register
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_insert = (in_command == rmss_pkg::CMD_INSERT);
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign do_insert = accept && is_insert && !full;

  // chain fill sizes: upper holds ceil(count/2), lower floor(count/2)
  assign u_size_w = ({1'b0, count_r} + 1'b1) >> 1;
  assign u_size   = u_size_w[CW-1:0];
  assign l_size   = count_r >> 1;

  // values handed across the split
  assign u_front = l_head_le ? l_head : in_value;
  assign l_front = u_head;

  // chain operations for one insert
  always_comb begin
    u_ctl.op    = rmss_pkg::OP_HOLD;
    u_ctl.value = in_value;
    l_ctl.op    = rmss_pkg::OP_HOLD;
    l_ctl.value = in_value;
    if (do_insert) begin
      if (empty) begin
        u_ctl.op = rmss_pkg::OP_INSERT;
      end else if (!count_r[0]) begin
        // even count: upper grows by one
        if (u_head_le) begin
          u_ctl.op = rmss_pkg::OP_INSERT;
        end else begin
          l_ctl.op = rmss_pkg::OP_POPINS;
          u_ctl.op = rmss_pkg::OP_PUSH;
        end
      end else begin
        // odd count: lower grows by one
        if (u_head_le) begin
          u_ctl.op = rmss_pkg::OP_POPINS;
          l_ctl.op = rmss_pkg::OP_PUSH;
        end else begin
          l_ctl.op = rmss_pkg::OP_INSERT;
        end
      end
    end
  end

  // upper half, ascending, head is the median
  rmss_chain #(
    .DEPTH   (NU),
    .SW      (CW),
    .DESCEND (1'b0)
  ) u_upper (
    .clk       (clk),
    .ctl_i     (u_ctl),
    .front_i   (u_front),
    .size_i    (u_size),
    .head_o    (u_head),
    .head_le_o (u_head_le)
  );

  // lower half, descending, head is the largest lower value
  rmss_chain #(
    .DEPTH   (NL),
    .SW      (CW),
    .DESCEND (1'b1)
  ) u_lower (
    .clk       (clk),
    .ctl_i     (l_ctl),
    .front_i   (l_front),
    .size_i    (l_size),
    .head_o    (l_head),
    .head_le_o (l_head_le)
  );

  // result of the accepted beat
  always_comb begin
    count_nxt  = do_insert ? count_r + 1'b1 : count_r;
    count_ext  = {{rmss_pkg::COUNT_W{1'b0}}, count_nxt};
    scount_nxt = count_ext[rmss_pkg::COUNT_W-1:0];
    median_nxt = '0;
    status_nxt = rmss_pkg::ST_OK;
    if (is_insert) begin
      if (full) status_nxt = rmss_pkg::ST_FULL;
    end else if (empty) begin
      status_nxt = rmss_pkg::ST_EMPTY;
    end else begin
      median_nxt = u_head;
    end
  end

  // count, output register and its valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (accept) begin
      median_r <= median_nxt;
      scount_r <= scount_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median       = median_r;
  assign out_stored_count = scount_r;
  assign out_status       = status_r;

  // count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count above capacity");

  // a rejected insert leaves the count alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_insert && full) |=> $stable(count_r))
    else $error("count moved on a rejected insert");

  // a query leaves the count alone
  a_query_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_insert) |=> $stable(count_r))
    else $error("count moved on a query");

  // only an ok query beat carries a median
  a_median_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == rmss_pkg::ST_FULL || status_r == rmss_pkg::ST_EMPTY))
      |-> (median_r == '0))
    else $error("nonzero median with error status");

endmodule
